// File: sv/psbr_pkg.sv
// Shared types, constants and rule-table functions for the pinyin syllable
// boundary rewriter. No dependencies; every module of the block imports it.
`default_nettype none

package psbr_pkg;

  // Default sizes
  localparam int WINDOW_BYTES_DEF = 4;
  localparam int QUEUE_DEPTH_DEF  = 4;

  // Number of window bytes a pattern can look at
  localparam int HEAD_BYTES = 4;

  localparam int NUM_RULES  = 25;
  localparam int RULE_W     = 5;
  localparam int LEN_W      = 3;

  // Rules from this index on start with a vowel and carry the separator
  // after their first letter; earlier rules carry it in front.
  localparam int FIRST_VOWEL_RULE = 19;

  localparam logic [7:0] APOSTROPHE = 8'h27;

  // Patterns, first letter in the top byte, zero padded on the right
  localparam logic [31:0] MATCH_STR [NUM_RULES] = '{
    {"ga", 16'h0}, {"ge", 16'h0}, {"gou", 8'h0}, "gong", {"gu", 16'h0},
    {"na", 16'h0}, {"ne", 16'h0}, {"ni", 16'h0}, {"nou", 8'h0}, "nong",
    {"nu", 16'h0}, {"nv", 16'h0}, {"ran", 8'h0}, {"rao", 8'h0},
    {"re", 16'h0}, {"ri", 16'h0}, {"rou", 8'h0}, "rong", {"ru", 16'h0},
    {"aou", 8'h0}, {"uou", 8'h0}, {"iai", 8'h0}, {"iei", 8'h0},
    {"uei", 8'h0}, {"vei", 8'h0}
  };

  localparam logic [LEN_W-1:0] MATCH_LEN [NUM_RULES] = '{
    3'd2, 3'd2, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd2, 3'd2, 3'd3, 3'd4,
    3'd2, 3'd2, 3'd3, 3'd3,
    3'd2, 3'd2, 3'd3, 3'd4, 3'd2,
    3'd3, 3'd3, 3'd3, 3'd3,
    3'd3, 3'd3
  };

  // Result of one decision at the head of the window
  typedef struct packed {
    logic              hit;
    logic [RULE_W-1:0] rule;
    logic [LEN_W-1:0]  len;
  } dec_t;

  // One queued decision: a rule replacement or a copied byte
  typedef struct packed {
    logic              is_copy;
    logic [RULE_W-1:0] rule;
    logic [7:0]        chr;
    logic              run_end;
    logic              string_end;
  } q_entry_t;

  // First matching rule in table order; avail is the number of bytes held
  function automatic dec_t find_rule(logic [31:0] head, logic [LEN_W-1:0] avail);
    dec_t d;
    logic ok;
    d.hit  = 1'b0;
    d.rule = '0;
    d.len  = LEN_W'(1);
    for (int r = NUM_RULES - 1; r >= 0; r--) begin
      ok = (MATCH_LEN[r] <= avail);
      for (int p = 0; p < HEAD_BYTES; p++) begin
        if (p < int'(MATCH_LEN[r]) &&
            head[31 - 8*p -: 8] != MATCH_STR[r][31 - 8*p -: 8]) begin
          ok = 1'b0;
        end
      end
      if (ok) begin
        d.hit  = 1'b1;
        d.rule = RULE_W'(r);
        d.len  = MATCH_LEN[r];
      end
    end
    return d;
  endfunction

  // Byte number idx of a rule's replacement text
  function automatic logic [7:0] repl_byte(logic [RULE_W-1:0] rule,
                                           logic [LEN_W-1:0] idx);
    logic [LEN_W-1:0] apos;
    logic [LEN_W-1:0] src;
    logic [31:0]      str;
    apos = (int'(rule) >= FIRST_VOWEL_RULE) ? LEN_W'(1) : LEN_W'(0);
    src  = (idx > apos) ? idx - LEN_W'(1) : idx;
    str  = MATCH_STR[rule] << {src, 3'b000};
    if (idx == apos) begin
      return APOSTROPHE;
    end
    return str[31:24];
  endfunction

endpackage

`default_nettype wire

// File: sv/psbr_queue.sv
// Short decision queue between the front and back parts of the rewriter.
// Depends on psbr_pkg for the entry type.
`default_nettype none

module psbr_queue
  import psbr_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire q_entry_t push_data,
  output logic          full,
  input  wire logic     pop,
  output logic          not_empty,
  output q_entry_t      pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t           entries_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = entries_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

  // The front never offers an entry when the queue is full.
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full)) else $error("decision pushed into a full queue");

  // Count goes up by one on a push without a pop.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("queue count did not advance on push");

endmodule

`default_nettype wire

// File: sv/psbr_front.sv
// Front part of the rewriter: accepts words into the lookahead window and
// takes rule decisions at its head. Depends on psbr_pkg.
`default_nettype none

module psbr_front
  import psbr_pkg::*;
#(
  parameter int WINDOW_BYTES = WINDOW_BYTES_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire logic [7:0] in_char,
  input  wire logic     in_last,
  output logic          q_push,
  output q_entry_t      q_data,
  input  wire logic     q_full
);

  localparam int FILL_W = $clog2(WINDOW_BYTES + 1);

  logic [7:0]        win_r   [WINDOW_BYTES];
  logic [7:0]        win_nxt [WINDOW_BYTES];
  logic [7:0]        ew      [WINDOW_BYTES + HEAD_BYTES];
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              flushing_r, flushing_nxt;
  logic              accept;
  logic              do_dec;
  logic              last_mode;
  logic [FILL_W-1:0] ef;
  logic [FILL_W-1:0] remaining;
  logic [LEN_W-1:0]  avail;
  logic [31:0]       head;
  dec_t              dec;

  assign in_ready = !flushing_r && !q_full;
  assign accept   = in_valid && in_ready;

  // Window as seen after this cycle's word is appended, padded with zeros
  always_comb begin
    for (int i = 0; i < WINDOW_BYTES + HEAD_BYTES; i++) begin
      ew[i] = 8'h00;
      if (i < WINDOW_BYTES) begin
        ew[i] = win_r[i];
        if (accept && FILL_W'(i) == fill_r) begin
          ew[i] = in_char;
        end
      end
    end
  end

  assign ef    = fill_r + FILL_W'(accept);
  assign avail = (ef > FILL_W'(HEAD_BYTES)) ? LEN_W'(HEAD_BYTES) : LEN_W'(ef);
  assign head  = {ew[0], ew[1], ew[2], ew[3]};
  assign dec   = find_rule(head, avail);

  // Decide when the window fills or a last word is taken, or every cycle while flushing and the queue has room
  assign last_mode = flushing_r || (accept && in_last);
  assign do_dec    = (accept && (in_last || ef == FILL_W'(WINDOW_BYTES))) ||
                     (flushing_r && !q_full);
  assign remaining = ef - FILL_W'(dec.len);

  // Queue entry for the decision
  always_comb begin
    q_push             = do_dec;
    q_data.is_copy     = !dec.hit;
    q_data.rule        = dec.rule;
    q_data.chr         = ew[0];
    q_data.run_end     = !last_mode || (remaining == '0);
    q_data.string_end  = last_mode && (remaining == '0);
  end

  // Window shift and flush control
  always_comb begin
    for (int i = 0; i < WINDOW_BYTES; i++) begin
      win_nxt[i] = ew[i];
      if (do_dec) begin
        for (int k = 1; k <= HEAD_BYTES; k++) begin
          if (dec.len == LEN_W'(k)) begin
            win_nxt[i] = ew[i + k];
          end
        end
      end
    end
    fill_nxt     = do_dec ? remaining : ef;
    flushing_nxt = flushing_r;
    if (last_mode && do_dec) begin
      flushing_nxt = (remaining != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      flushing_r <= 1'b0;
    end else begin
      fill_r     <= fill_nxt;
      flushing_r <= flushing_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < WINDOW_BYTES; i++) begin
      win_r[i] <= win_nxt[i];
    end
  end

  // A full window is always decided in the cycle it fills.
  a_fill_below_size: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r < FILL_W'(WINDOW_BYTES)) else $error("window left full");

  // Flushing only runs while bytes remain.
  a_flush_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    flushing_r |-> (fill_r != '0)) else $error("flushing an empty window");

  // A taken last word always gives a decision.
  a_last_decides: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last) |-> q_push) else $error("last word gave no decision");

endmodule

`default_nettype wire

// File: sv/psbr_back.sv
// Back part of the rewriter: expands queued decisions into output bytes
// behind an output register. Depends on psbr_pkg.
`default_nettype none

module psbr_back
  import psbr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_not_empty,
  input  wire q_entry_t   q_data,
  output logic            q_pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_char,
  output logic            out_run_end,
  output logic            out_string_end
);

  q_entry_t          cur_r;
  logic              cur_valid_r;
  logic [LEN_W-1:0]  idx_r;
  logic              out_valid_r;
  logic [7:0]        out_char_r;
  logic              out_run_end_r;
  logic              out_string_end_r;
  logic              can_load;
  logic              emit;
  logic              last_byte;
  logic [LEN_W-1:0]  cur_len;
  logic [7:0]        cur_byte;

  assign can_load  = !out_valid_r || out_ready;
  assign cur_len   = cur_r.is_copy ? LEN_W'(1) : MATCH_LEN[cur_r.rule] + LEN_W'(1);
  assign last_byte = (idx_r == cur_len - LEN_W'(1));
  assign cur_byte  = cur_r.is_copy ? cur_r.chr : repl_byte(cur_r.rule, idx_r);
  assign emit      = cur_valid_r && can_load;
  assign q_pop     = q_not_empty && (!cur_valid_r || (emit && last_byte));

  // Current decision and byte position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (q_pop) begin
      cur_valid_r <= 1'b1;
      idx_r       <= '0;
    end else if (emit && last_byte) begin
      cur_valid_r <= 1'b0;
    end else if (emit) begin
      idx_r <= idx_r + LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char_r       <= cur_byte;
      out_run_end_r    <= cur_r.run_end && last_byte;
      out_string_end_r <= cur_r.string_end && last_byte;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_char       = out_char_r;
  assign out_run_end    = out_run_end_r;
  assign out_string_end = out_string_end_r;

  // The end of a string is always the end of a run.
  a_string_end_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_string_end) |-> out_run_end)
    else $error("string end without run end");

  // Byte position stays inside the replacement text.
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (idx_r < cur_len)) else $error("byte index past replacement");

endmodule

`default_nettype wire

// File: sv/pinyin_syllable_boundary_rewriter_unit.sv
// Top level of the pinyin syllable boundary rewriter: front, decision
// queue and back. Depends on psbr_pkg, psbr_front, psbr_queue, psbr_back.
//
//   Channel | Direction | Handshake            | Word
//   in_     | input     | in_valid / in_ready  | in_char[7:0], in_last
//   out_    | output    | out_valid / out_ready| out_char[7:0], out_run_end,
//           |           |                      | out_string_end
//
// A word that fills the window is decided in the cycle it is taken, so
// words can arrive back to back while the queue has room.
// Output bytes leave at one per cycle from the back part while out_ready
// is high; a replacement is its pattern and the separator, up to five
// bytes, so throughput is set by the output byte rate. A last word blocks
// input while the window drains, one decision a cycle if the queue has room.
// Reset is synchronous, active low, and empties window, queue and outputs.
// A stalled output fills the queue, after which in_ready drops.
`default_nettype none

module pinyin_syllable_boundary_rewriter_unit
  import psbr_pkg::*;
#(
  parameter int WINDOW_BYTES = WINDOW_BYTES_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_char,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_char,
  output logic            out_run_end,
  output logic            out_string_end
);

  q_entry_t push_data;
  q_entry_t pop_data;
  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_not_empty;

  // Window and decisions
  psbr_front #(
    .WINDOW_BYTES(WINDOW_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_char  (in_char),
    .in_last  (in_last),
    .q_push   (push),
    .q_data   (push_data),
    .q_full   (q_full)
  );

  // Decision queue
  psbr_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .pop_data  (pop_data)
  );

  // Byte expansion and output register
  psbr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_not_empty    (q_not_empty),
    .q_data         (pop_data),
    .q_pop          (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char       (out_char),
    .out_run_end    (out_run_end),
    .out_string_end (out_string_end)
  );

endmodule

`default_nettype wire
